>>> src/iair_pkg.sv
// ---------------------------------------------------------------------------
// iair_pkg
// Shared sizes, codes and controller/datapath types for the indexed array
// insert/remove unit.
// ---------------------------------------------------------------------------
package iair_pkg;

    // Store geometry
    localparam int DEPTH    = 1024;
    localparam int WIDTH    = 32;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int LEN_W    = ADDR_W + 1;

    // Word field widths
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 11;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 11;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_FILL   = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GET_WAIT,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_REM_READ,
        S_REM_SHIFT,
        S_FILL,
        S_DONE
    } state_t;

    // Read address select
    typedef enum logic [2:0] {
        RA_IDX,
        RA_IDX_P1,
        RA_CNT_M1,
        RA_PTR_M2,
        RA_PTR_P2
    } ra_sel_t;

    // Write address select
    typedef enum logic {
        WA_IDX,
        WA_PTR
    } wa_sel_t;

    // Write data select
    typedef enum logic {
        WD_VALUE,
        WD_RDATA
    } wd_sel_t;

    // Pointer update
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_CNT,
        PTR_IDX,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    // Length update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_LOAD
    } cnt_op_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    chk;
        logic    mem_we;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        ra_sel_t ra_sel;
        ptr_op_t ptr_op;
        cnt_op_t cnt_op;
        logic    cap_rd;
        logic    out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            err;
        logic            idx_eq_cnt;
        logic            idx_zero;
        logic            ins_last;
        logic            rem_more;
        logic            down_more;
        logic            fill_last;
        logic            out_free;
    } stat_t;

endpackage

>>> src/iair_req_if.sv
// ---------------------------------------------------------------------------
// iair_req_if
// Request channel: valid/ready handshake carrying op, index and value.
// ---------------------------------------------------------------------------
interface iair_req_if;

    logic                        valid;
    logic                        ready;
    logic [iair_pkg::OP_W-1:0]    op;
    logic [iair_pkg::INDEX_W-1:0] index;
    logic [iair_pkg::VALUE_W-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);

endinterface

>>> src/iair_rsp_if.sv
// ---------------------------------------------------------------------------
// iair_rsp_if
// Result channel: valid/ready handshake carrying read_value, status, length.
// ---------------------------------------------------------------------------
interface iair_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [iair_pkg::VALUE_W-1:0]  read_value;
    logic [iair_pkg::STATUS_W-1:0] status;
    logic [iair_pkg::LENGTH_W-1:0] length;

    modport source (output valid, output read_value, output status, output length,
                    input ready);
    modport sink   (input valid, input read_value, input status, input length,
                    output ready);

endinterface

>>> src/iair_dp.sv
// ---------------------------------------------------------------------------
// iair_dp
// Datapath: request registers, entry store, length, shift pointer and the
// result register.
// ---------------------------------------------------------------------------
module iair_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  iair_pkg::cmd_t  cmd,
    output iair_pkg::stat_t stat,
    iair_req_if.sink        req,
    iair_rsp_if.source      rsp
);

    localparam int AW = iair_pkg::ADDR_W;
    localparam int LW = iair_pkg::LEN_W;

    // Entry store
    logic [iair_pkg::WIDTH-1:0] entries_mem [iair_pkg::DEPTH];
    logic [iair_pkg::WIDTH-1:0] rdata_reg;

    // Request and working registers
    logic [iair_pkg::OP_W-1:0]     op_reg;
    logic [iair_pkg::INDEX_W-1:0]  idx_reg;
    logic [iair_pkg::WIDTH-1:0]    value_reg;
    logic [LW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [iair_pkg::WIDTH-1:0]    rd_reg;
    iair_pkg::status_t             st_reg;

    // Result register
    logic                          out_valid_reg;
    logic [iair_pkg::VALUE_W-1:0]  out_value_reg;
    iair_pkg::status_t             out_status_reg;
    logic [iair_pkg::LENGTH_W-1:0] out_length_reg;

    logic [AW-1:0]              raddr;
    logic [AW-1:0]              waddr;
    logic [iair_pkg::WIDTH-1:0] wdata;
    iair_pkg::status_t          st_calc;
    logic [LW:0]                ptr_p2_w;

    // Request checks
    always_comb
    begin
        st_calc = iair_pkg::ST_OK;
        case (op_reg)
            iair_pkg::OP_GET, iair_pkg::OP_SET, iair_pkg::OP_REMOVE:
            begin
                if (idx_reg >= count_reg)
                    st_calc = iair_pkg::ST_RANGE;
            end
            iair_pkg::OP_INSERT:
            begin
                if (idx_reg > count_reg)
                    st_calc = iair_pkg::ST_RANGE;
                else if (count_reg >= LW'(iair_pkg::DEPTH))
                    st_calc = iair_pkg::ST_FULL;
            end
            iair_pkg::OP_FILL:
            begin
                if (idx_reg > LW'(iair_pkg::DEPTH))
                    st_calc = iair_pkg::ST_FULL;
            end
            default:
            begin
                st_calc = iair_pkg::ST_OK;
            end
        endcase
    end

    // Status to controller
    assign ptr_p2_w = {1'b0, LW'(ptr_reg)} + (LW + 1)'(2);

    always_comb
    begin
        stat.op         = op_reg;
        stat.err        = (st_calc != iair_pkg::ST_OK);
        stat.idx_eq_cnt = (idx_reg == count_reg);
        stat.idx_zero   = (idx_reg == '0);
        stat.ins_last   = (LW'(ptr_reg) == idx_reg + LW'(1));
        stat.rem_more   = ({1'b0, idx_reg} + (LW + 1)'(1)) < {1'b0, count_reg};
        stat.down_more  = ptr_p2_w < {1'b0, count_reg};
        stat.fill_last  = (LW'(ptr_reg) + LW'(1) == idx_reg);
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    // Address and data selection
    always_comb
    begin
        case (cmd.ra_sel)
            iair_pkg::RA_IDX:    raddr = idx_reg[AW-1:0];
            iair_pkg::RA_IDX_P1: raddr = idx_reg[AW-1:0] + AW'(1);
            iair_pkg::RA_CNT_M1: raddr = count_reg[AW-1:0] - AW'(1);
            iair_pkg::RA_PTR_M2: raddr = ptr_reg - AW'(2);
            iair_pkg::RA_PTR_P2: raddr = ptr_reg + AW'(2);
            default:             raddr = idx_reg[AW-1:0];
        endcase
        waddr = (cmd.wa_sel == iair_pkg::WA_PTR) ? ptr_reg : idx_reg[AW-1:0];
        wdata = (cmd.wd_sel == iair_pkg::WD_RDATA) ? rdata_reg : value_reg;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            entries_mem[waddr] <= wdata;
        rdata_reg <= entries_mem[raddr];
    end

    // Pointer and length next values
    always_comb
    begin
        case (cmd.ptr_op)
            iair_pkg::PTR_CNT:  ptr_next = count_reg[AW-1:0];
            iair_pkg::PTR_IDX:  ptr_next = idx_reg[AW-1:0];
            iair_pkg::PTR_ZERO: ptr_next = '0;
            iair_pkg::PTR_INC:  ptr_next = ptr_reg + AW'(1);
            iair_pkg::PTR_DEC:  ptr_next = ptr_reg - AW'(1);
            default:            ptr_next = ptr_reg;
        endcase
        case (cmd.cnt_op)
            iair_pkg::CNT_INC:  count_next = count_reg + LW'(1);
            iair_pkg::CNT_DEC:  count_next = count_reg - LW'(1);
            iair_pkg::CNT_LOAD: count_next = LW'(idx_reg);
            default:            count_next = count_reg;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= req.op;
            idx_reg   <= req.index;
            value_reg <= iair_pkg::WIDTH'(req.value);
        end
        ptr_reg <= ptr_next;
        if (cmd.load_req)
            rd_reg <= '0;
        else if (cmd.cap_rd)
            rd_reg <= rdata_reg;
        if (cmd.chk)
            st_reg <= st_calc;
        if (cmd.out_load)
        begin
            out_value_reg  <= iair_pkg::VALUE_W'(rd_reg);
            out_status_reg <= st_reg;
            out_length_reg <= iair_pkg::LENGTH_W'(count_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.length     = out_length_reg;

endmodule

>>> src/iair_ctrl.sv
// ---------------------------------------------------------------------------
// iair_ctrl
// Controller: sequences checks, reads, shifts and fills one entry a cycle.
// ---------------------------------------------------------------------------
module iair_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  iair_pkg::stat_t stat,
    output iair_pkg::cmd_t  cmd
);

    iair_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iair_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iair_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = iair_pkg::S_CHECK;
            end
            iair_pkg::S_CHECK:
            begin
                if (stat.err)
                    state_next = iair_pkg::S_DONE;
                else
                begin
                    case (stat.op)
                        iair_pkg::OP_GET:
                            state_next = iair_pkg::S_GET_WAIT;
                        iair_pkg::OP_INSERT:
                            state_next = stat.idx_eq_cnt ? iair_pkg::S_DONE
                                                         : iair_pkg::S_INS_SHIFT;
                        iair_pkg::OP_REMOVE:
                            state_next = iair_pkg::S_REM_READ;
                        iair_pkg::OP_FILL:
                            state_next = stat.idx_zero ? iair_pkg::S_DONE
                                                       : iair_pkg::S_FILL;
                        default:
                            state_next = iair_pkg::S_DONE;
                    endcase
                end
            end
            iair_pkg::S_GET_WAIT:
                state_next = iair_pkg::S_DONE;
            iair_pkg::S_INS_SHIFT:
            begin
                if (stat.ins_last)
                    state_next = iair_pkg::S_INS_WRITE;
            end
            iair_pkg::S_INS_WRITE:
                state_next = iair_pkg::S_DONE;
            iair_pkg::S_REM_READ:
                state_next = stat.rem_more ? iair_pkg::S_REM_SHIFT : iair_pkg::S_DONE;
            iair_pkg::S_REM_SHIFT:
            begin
                if (!stat.down_more)
                    state_next = iair_pkg::S_DONE;
            end
            iair_pkg::S_FILL:
            begin
                if (stat.fill_last)
                    state_next = iair_pkg::S_DONE;
            end
            iair_pkg::S_DONE:
            begin
                if (stat.out_free)
                    state_next = iair_pkg::S_IDLE;
            end
            default:
                state_next = iair_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        req_ready    = 1'b0;
        cmd.load_req = 1'b0;
        cmd.chk      = 1'b0;
        cmd.mem_we   = 1'b0;
        cmd.wa_sel   = iair_pkg::WA_IDX;
        cmd.wd_sel   = iair_pkg::WD_VALUE;
        cmd.ra_sel   = iair_pkg::RA_IDX;
        cmd.ptr_op   = iair_pkg::PTR_HOLD;
        cmd.cnt_op   = iair_pkg::CNT_HOLD;
        cmd.cap_rd   = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            iair_pkg::S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            iair_pkg::S_CHECK:
            begin
                cmd.chk = 1'b1;
                if (!stat.err)
                begin
                    case (stat.op)
                        iair_pkg::OP_GET:
                            cmd.ra_sel = iair_pkg::RA_IDX;
                        iair_pkg::OP_SET:
                            cmd.mem_we = 1'b1;
                        iair_pkg::OP_INSERT:
                        begin
                            // appending needs no shift
                            if (stat.idx_eq_cnt)
                            begin
                                cmd.mem_we = 1'b1;
                                cmd.cnt_op = iair_pkg::CNT_INC;
                            end
                            else
                            begin
                                cmd.ra_sel = iair_pkg::RA_CNT_M1;
                                cmd.ptr_op = iair_pkg::PTR_CNT;
                            end
                        end
                        iair_pkg::OP_REMOVE:
                        begin
                            cmd.ra_sel = iair_pkg::RA_IDX;
                            cmd.ptr_op = iair_pkg::PTR_IDX;
                        end
                        iair_pkg::OP_FILL:
                        begin
                            if (stat.idx_zero)
                                cmd.cnt_op = iair_pkg::CNT_LOAD;
                            else
                                cmd.ptr_op = iair_pkg::PTR_ZERO;
                        end
                        default:
                            cmd.chk = 1'b1;
                    endcase
                end
            end
            iair_pkg::S_GET_WAIT:
                cmd.cap_rd = 1'b1;
            iair_pkg::S_INS_SHIFT:
            begin
                // move entry ptr-1 up to ptr
                cmd.mem_we = 1'b1;
                cmd.wa_sel = iair_pkg::WA_PTR;
                cmd.wd_sel = iair_pkg::WD_RDATA;
                if (!stat.ins_last)
                begin
                    cmd.ra_sel = iair_pkg::RA_PTR_M2;
                    cmd.ptr_op = iair_pkg::PTR_DEC;
                end
            end
            iair_pkg::S_INS_WRITE:
            begin
                cmd.mem_we = 1'b1;
                cmd.cnt_op = iair_pkg::CNT_INC;
            end
            iair_pkg::S_REM_READ:
            begin
                cmd.cap_rd = 1'b1;
                if (stat.rem_more)
                    cmd.ra_sel = iair_pkg::RA_IDX_P1;
                else
                    cmd.cnt_op = iair_pkg::CNT_DEC;
            end
            iair_pkg::S_REM_SHIFT:
            begin
                // move entry ptr+1 down to ptr
                cmd.mem_we = 1'b1;
                cmd.wa_sel = iair_pkg::WA_PTR;
                cmd.wd_sel = iair_pkg::WD_RDATA;
                if (stat.down_more)
                begin
                    cmd.ra_sel = iair_pkg::RA_PTR_P2;
                    cmd.ptr_op = iair_pkg::PTR_INC;
                end
                else
                    cmd.cnt_op = iair_pkg::CNT_DEC;
            end
            iair_pkg::S_FILL:
            begin
                cmd.mem_we = 1'b1;
                cmd.wa_sel = iair_pkg::WA_PTR;
                if (stat.fill_last)
                    cmd.cnt_op = iair_pkg::CNT_LOAD;
                else
                    cmd.ptr_op = iair_pkg::PTR_INC;
            end
            iair_pkg::S_DONE:
                cmd.out_load = stat.out_free;
            default:
                req_ready = 1'b0;
        endcase
    end

endmodule

>>> src/indexed_array_insert_remove_unit.sv
// ---------------------------------------------------------------------------
// indexed_array_insert_remove_unit
// Ordered word array with get, set, insert, remove and fill on a fixed store.
// ---------------------------------------------------------------------------
// One request is handled at a time; each gives exactly one result word
// carrying the read or removed value, a status and the new length. The store
// is a single memory with one write and one registered read port, so every
// shift or fill moves one entry per cycle. A finished result sits in an
// output register, so the next request is taken while it waits. Entries at
// or above the length hold stale data and are never returned.
// ---------------------------------------------------------------------------
module indexed_array_insert_remove_unit (
    input  logic       clk,
    input  logic       rst_n,
    iair_req_if.sink   req,
    iair_rsp_if.source rsp
);

    iair_pkg::cmd_t  cmd;
    iair_pkg::stat_t stat;

    // Sequencer
    iair_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store and result path
    iair_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> tb/sv/array_op_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// array_op_checker
// Watches the request and result channels of the indexed array unit, keeps
// its own copy of the array and its length, works out the result of every
// accepted request and compares each accepted result word against the
// oldest one still waiting.
// ---------------------------------------------------------------------------
module array_op_checker (
    input  logic        clk,
    input  logic        rst_n,
    iair_req_if         req,
    iair_rsp_if         rsp,
    output int          mismatch_count,
    output int          outstanding
);

    import iair_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        status_t             status;
        logic [LENGTH_W-1:0] length;
    } array_result_t;

    // Shadow of the array contents and its length
    logic [WIDTH-1:0]    shadow_store [DEPTH];
    logic [LENGTH_W-1:0] shadow_len;

    array_result_t pending_results[$];

    // Apply one request to the shadow array and return the result it gives
    function automatic array_result_t apply_request(input logic [OP_W-1:0] op,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [VALUE_W-1:0] word);
        array_result_t res;
        int            pos;
        res.read_value = '0;
        res.status     = ST_OK;
        case (op)
            OP_GET:
                if (idx >= shadow_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = shadow_store[idx[ADDR_W-1:0]];
            OP_SET:
                if (idx >= shadow_len)
                    res.status = ST_RANGE;
                else
                    shadow_store[idx[ADDR_W-1:0]] = word[WIDTH-1:0];
            OP_INSERT:
                // range test wins over the full test
                if (idx > shadow_len)
                    res.status = ST_RANGE;
                else if (shadow_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (pos = shadow_len; pos > idx; pos--)
                        shadow_store[pos] = shadow_store[pos-1];
                    shadow_store[idx[ADDR_W-1:0]] = word[WIDTH-1:0];
                    shadow_len++;
                end
            OP_REMOVE:
                if (idx >= shadow_len)
                    res.status = ST_RANGE;
                else
                begin
                    res.read_value = shadow_store[idx[ADDR_W-1:0]];
                    for (pos = idx; pos + 1 < shadow_len; pos++)
                        shadow_store[pos] = shadow_store[pos+1];
                    shadow_len--;
                end
            OP_FILL:
                if (idx > DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (pos = 0; pos < idx; pos++)
                        shadow_store[pos] = word[WIDTH-1:0];
                    shadow_len = idx;
                end
            default:
                ; // spare codes leave everything alone
        endcase
        res.length = shadow_len;
        return res;
    endfunction

    // Compare result words as they leave, predict as requests enter
    always @(posedge clk or negedge rst_n)
    begin
        array_result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            shadow_len     = '0;
            mismatch_count = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word: read_value %h status %0d length %0d",
                           rsp.read_value, rsp.status, rsp.length);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, actual %h",
                               want.read_value, rsp.read_value);
                        mismatch_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp.status);
                        mismatch_count++;
                    end
                    if (rsp.length !== want.length)
                    begin
                        $error("length: expected %0d, actual %0d", want.length, rsp.length);
                        mismatch_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_request(req.op, req.index, req.value));
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> tb/sv/indexed_array_insert_remove_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// indexed_array_insert_remove_unit_tb
// Drives request words into the indexed array unit and gives the verdict.
// A directed run covers empty, full and out-of-range cases, long shifts at
// full capacity and the spare op codes; random phases follow with varying
// request gaps and result back-pressure. Checking is done by the checker.
// ---------------------------------------------------------------------------
module indexed_array_insert_remove_unit_tb;

    import iair_pkg::*;

    localparam logic [OP_W-1:0]    OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0]    OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0]    OP_SPARE_HI  = 3'd7;
    localparam logic [INDEX_W-1:0] IDX_MAX      = '1;

    logic clk = 1'b0;
    logic rst_n;

    iair_req_if req_ch ();
    iair_rsp_if rsp_ch ();

    int mismatch_count;
    int outstanding;
    int send_idle_pct;
    int stall_pct;
    int stall_left;
    int gen_len;   // array length as seen by the generator, for index steering

    indexed_array_insert_remove_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    array_op_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    // Result back-pressure: random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_pct == 0)
        begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= int'($urandom_range(11));
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Present one word, with an optional gap first; valid stays high after
    task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] word);
        int gap;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = int'($urandom_range(1, 12));
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.index <= idx;
        req_ch.value <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        case (op)
            OP_INSERT: if (idx <= gen_len && gen_len < DEPTH) gen_len++;
            OP_REMOVE: if (idx < gen_len) gen_len--;
            OP_FILL:   if (idx <= DEPTH) gen_len = idx;
            default:   ;
        endcase
    endtask

    // Stop sending and wait until every result word has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Mostly a valid position, sometimes past the end
    function automatic logic [INDEX_W-1:0] pick_index(input bit allow_end);
        int last_pos;
        last_pos = allow_end ? gen_len : gen_len - 1;
        if (last_pos < 0 || $urandom_range(9) == 0)
            return INDEX_W'($urandom_range(last_pos + 1, IDX_MAX));
        return INDEX_W'($urandom_range(0, last_pos));
    endfunction

    task automatic send_random_word();
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] word;
        pick = int'($urandom_range(99));
        word = $urandom;
        if ($urandom_range(15) == 0)
            word = $urandom_range(1) ? '1 : '0;
        // keep the array short most of the time so shifts stay cheap
        if (gen_len > 64 && pick < 30)
        begin
            op  = OP_FILL;
            idx = INDEX_W'($urandom_range(24));
        end
        else if (pick < 18)
        begin
            op  = OP_GET;
            idx = pick_index(1'b0);
        end
        else if (pick < 32)
        begin
            op  = OP_SET;
            idx = pick_index(1'b0);
        end
        else if (pick < 58)
        begin
            op  = OP_INSERT;
            idx = pick_index(1'b1);
        end
        else if (pick < 80)
        begin
            op  = OP_REMOVE;
            idx = pick_index(1'b0);
        end
        else if (pick < 88)
        begin
            op  = OP_FILL;
            idx = ($urandom_range(19) == 0) ? INDEX_W'($urandom_range(1000, DEPTH))
                                            : INDEX_W'($urandom_range(32));
        end
        else if (pick < 93)
        begin
            op  = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            idx = INDEX_W'($urandom_range(IDX_MAX));
        end
        else
        begin
            // noise: any code, any index
            op  = OP_W'($urandom_range(7));
            idx = INDEX_W'($urandom_range(IDX_MAX));
        end
        send_word(op, idx, word);
    endtask

    task automatic run_phase(input int items, input int idle_pct, input int hold_pct);
        send_idle_pct  = idle_pct;
        stall_pct     <= hold_pct;
        repeat (items)
            send_random_word();
        drain_results();
    endtask

    // Hard stop
    initial
    begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.op     <= OP_GET;
        req_ch.index  <= '0;
        req_ch.value  <= '0;
        send_idle_pct  = 20;
        stall_pct     <= 20;
        gen_len        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty array: every access is out of range
        send_word(OP_GET, '0, '0);
        send_word(OP_SET, '0, 32'h1111_1111);
        send_word(OP_REMOVE, '0, '0);
        send_word(OP_INSERT, 11'd1, '1);
        // build a short list: append, head, middle
        send_word(OP_INSERT, '0, '1);
        send_word(OP_INSERT, 11'd1, '0);
        send_word(OP_INSERT, '0, 32'hA5A5_A5A5);
        send_word(OP_INSERT, 11'd1, 32'h1234_5678);
        send_word(OP_GET, 11'd3, '0);
        send_word(OP_GET, 11'd4, '0);
        send_word(OP_SET, 11'd2, 32'h5A5A_5A5A);
        send_word(OP_REMOVE, 11'd1, '0);
        send_word(OP_REMOVE, 11'd2, '0);
        // zero fill, spare codes, fills past capacity
        send_word(OP_FILL, '0, 32'hFFFF_0000);
        send_word(OP_SPARE_LO, IDX_MAX, '1);
        send_word(OP_SPARE_MID, 11'd3, 32'h0F0F_0F0F);
        send_word(OP_SPARE_HI, '0, '0);
        send_word(OP_FILL, INDEX_W'(DEPTH + 1), '1);
        send_word(OP_FILL, IDX_MAX, '0);
        // full array: insert at the end and the head is refused, long shifts
        send_word(OP_FILL, INDEX_W'(DEPTH), 32'hDEAD_BEEF);
        send_word(OP_INSERT, INDEX_W'(DEPTH), '0);
        send_word(OP_INSERT, '0, '0);
        send_word(OP_INSERT, INDEX_W'(DEPTH + 1), '0);
        send_word(OP_GET, INDEX_W'(DEPTH - 1), '0);
        send_word(OP_SET, INDEX_W'(DEPTH - 1), '0);
        send_word(OP_REMOVE, '0, '0);
        send_word(OP_GET, INDEX_W'(DEPTH - 2), '0);
        send_word(OP_INSERT, '0, 32'h0000_0001);
        send_word(OP_FILL, 11'd3, '0);
        drain_results();

        // random phases with different idle and stall mixes, calm at the end
        run_phase(110, 25, 25);
        run_phase(110, 0, 0);
        run_phase(110, 60, 10);
        run_phase(110, 10, 60);
        run_phase(110, 0, 0);

        repeat (DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
